// ----- src/wrapped_image_convolution_core_assert.svh -----
// Assertion macros shared by the convolution core.
`ifndef WRAPPED_IMAGE_CONVOLUTION_CORE_ASSERT_SVH
`define WRAPPED_IMAGE_CONVOLUTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("convolution core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("convolution core check failed");

`endif

// ----- src/wic_pkg.sv -----
// Shared types and constants of the wrapped image convolution core.
`timescale 1ns / 1ps

package wic_pkg;

    // Fixed field widths.
    localparam int COORD_W = 6;
    localparam int BIT_W   = $clog2(COORD_W);
    localparam int CHAN_W  = 8;
    localparam int OFFS_W  = 2 * CHAN_W;

    // Item actions.
    localparam logic [1:0] ACT_TAP    = 2'd0;
    localparam logic [1:0] ACT_PIXEL  = 2'd1;
    localparam logic [1:0] ACT_FILTER = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KERNEL_WIDTH = 3'd2;
    localparam logic [2:0] REG_DIVISOR      = 3'd3;
    localparam logic [2:0] REG_BIAS         = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MOD,
        SC_ADJ,
        SC_WALK
    } t_scan_state;

    typedef struct packed {
        logic rd_en;
        logic last;
    } t_scan_ctl;

endpackage

// ----- src/wic_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module wic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/wic_scan.sv -----
// Window scanner: centre reduction, wrapped start and kernel-square address walk.
`timescale 1ns / 1ps

module wic_scan
    import wic_pkg::*;
#(
    parameter int MAX_DIM = 64,
    parameter int MAX_KERNEL = 9,
    localparam int CW  = $clog2(MAX_DIM),
    localparam int AW  = $clog2(MAX_DIM * MAX_DIM),
    localparam int KCW = $clog2(MAX_KERNEL + 1),
    localparam int KAW = $clog2(MAX_KERNEL * MAX_KERNEL)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic [CW:0]        i_width,
    input  logic [CW:0]        i_height,
    input  logic [KCW-1:0]     i_kw,
    output logic [AW-1:0]      o_pix_addr,
    output logic [KAW-1:0]     o_tap_addr,
    output t_scan_ctl          o_ctl
);

    // Signed position width: room for a centre less half a kernel.
    localparam int SW = ((CW > 3) ? CW : 3) + 1;

    t_scan_state        r_state, n_state;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [CW-1:0]      r_rem_x, n_rem_x;
    logic [CW-1:0]      r_rem_y, n_rem_y;
    logic [SW-1:0]      r_px, n_px;
    logic [SW-1:0]      r_py, n_py;
    logic [SW-1:0]      r_py0, n_py0;
    logic [KCW-1:0]     r_fx, n_fx;
    logic [KCW-1:0]     r_fy, n_fy;
    logic [KAW-1:0]     r_tap, n_tap;

    logic [CW:0]    tx, ty, inc_x, inc_y;
    logic [CW-1:0]  mx, my;
    logic [KCW-1:0] half, kw_last;
    logic           col_end, is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_col   <= n_col;
        r_row   <= n_row;
        r_bit   <= n_bit;
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_px    <= n_px;
        r_py    <= n_py;
        r_py0   <= n_py0;
        r_fx    <= n_fx;
        r_fy    <= n_fy;
        r_tap   <= n_tap;
    end

    always_comb begin
        // One restoring step of the centre reduction modulo the image size.
        tx = {r_rem_x, r_col[r_bit]};
        ty = {r_rem_y, r_row[r_bit]};
        mx = (tx >= i_width)  ? CW'(tx - i_width)  : CW'(tx);
        my = (ty >= i_height) ? CW'(ty - i_height) : CW'(ty);

        half    = i_kw >> 1;
        kw_last = i_kw - KCW'(1);
        col_end = (r_fy == kw_last);
        is_last = col_end && (r_fx == kw_last);
        inc_x   = {1'b0, r_px[CW-1:0]} + (CW+1)'(1);
        inc_y   = {1'b0, r_py[CW-1:0]} + (CW+1)'(1);

        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_bit   = r_bit;
        n_rem_x = r_rem_x;
        n_rem_y = r_rem_y;
        n_px    = r_px;
        n_py    = r_py;
        n_py0   = r_py0;
        n_fx    = r_fx;
        n_fy    = r_fy;
        n_tap   = r_tap;

        case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_col   = i_col;
                    n_row   = i_row;
                    n_rem_x = '0;
                    n_rem_y = '0;
                    n_bit   = BIT_W'(COORD_W - 1);
                    n_state = SC_MOD;
                end
            end
            SC_MOD: begin
                n_rem_x = mx;
                n_rem_y = my;
                n_bit   = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_px    = SW'(mx) - SW'(half);
                    n_py    = SW'(my) - SW'(half);
                    n_state = SC_ADJ;
                end
            end
            SC_ADJ: begin
                // Fold a negative start back into the image, one size at a time.
                if (r_px[SW-1]) begin
                    n_px = r_px + SW'(i_width);
                end
                if (r_py[SW-1]) begin
                    n_py = r_py + SW'(i_height);
                end
                if (!r_px[SW-1] && !r_py[SW-1]) begin
                    n_py0   = r_py;
                    n_fx    = '0;
                    n_fy    = '0;
                    n_tap   = '0;
                    n_state = SC_WALK;
                end
            end
            SC_WALK: begin
                n_tap = r_tap + KAW'(1);
                if (col_end) begin
                    n_fy = '0;
                    n_py = r_py0;
                    n_fx = r_fx + KCW'(1);
                    n_px = (inc_x == i_width) ? '0 : SW'(inc_x);
                end else begin
                    n_fy = r_fy + KCW'(1);
                    n_py = (inc_y == i_height) ? '0 : SW'(inc_y);
                end
                if (is_last) begin
                    n_state = SC_IDLE;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    assign o_pix_addr = AW'(r_px[CW-1:0]) * AW'(MAX_DIM) + AW'(r_py[CW-1:0]);
    assign o_tap_addr = r_tap;
    assign o_ctl.rd_en = (r_state == SC_WALK);
    assign o_ctl.last  = (r_state == SC_WALK) && is_last;

endmodule

// ----- src/wic_div.sv -----
// Biased, clamped quotient of one channel sum by the divisor, one bit per cycle.
`timescale 1ns / 1ps

module wic_div
    import wic_pkg::*;
#(
    parameter int W = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_sum,
    input  logic [OFFS_W-1:0]   i_offset,
    input  logic [CHAN_W-1:0]   i_divisor,
    output logic                o_done,
    output logic [CHAN_W-1:0]   o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic signed [W-1:0] r_rem;
    logic [CHAN_W-1:0]   r_quot;

    logic [W-1:0]        dsh;
    logic signed [W-1:0] trial;
    logic                fits;

    // A negative numerator never subtracts and ends at zero; one of 256 divisors
    // or more subtracts at every step and ends at the all-ones maximum.
    assign dsh   = W'(i_divisor) << r_cnt;
    assign trial = r_rem - $signed(dsh);
    assign fits  = !trial[W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem  <= i_sum + $signed({{(W - OFFS_W){1'b0}}, i_offset});
            r_cnt  <= 3'd7;
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= trial;
            end
            r_quot <= {r_quot[CHAN_W-2:0], fits};
            r_cnt  <= r_cnt - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- src/wrapped_image_convolution_core.sv -----
// Top level of the wrapped image convolution core.
`timescale 1ns / 1ps
// Usage. An item is transferred at a rising edge where start is high and busy is low.
// i_action selects a kernel tap write, a pixel write or a filter request; the
// other input fields carry the tap, the pixel or the requested column and row.
// Tap and pixel writes complete in the cycle of transfer and busy stays low.
// A filter request raises busy until its result is presented: o_valid is high
// for exactly one cycle with the three clamped channels and the echoed column
// and row. The receiver cannot hold a result off, so none waits anywhere.
// A filter request runs a six-step reduction of the centre modulo the image size,
// a fold of the window start back into the image (repeated when it wraps in a
// tiny image), a walk of the window through the single read port of the pixel
// store, one window pixel per cycle, and an eight-step divider per channel.
// A new item is taken in the cycle the strobe is shown.
// Registers sit on an APB-style port at byte address 4*index; pready is always
// high and reads return the stored value. Write them only while busy is low.
// Reset restores the register defaults and idles the sequencers. The pixel and
// kernel stores are not cleared: entries are undefined until written.
`include "wrapped_image_convolution_core_assert.svh"

module wrapped_image_convolution_core
    import wic_pkg::*;
#(
    parameter int MAX_DIM = 64,
    parameter int MAX_KERNEL = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Command channel.
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_action,
    input  logic [6:0]                i_tap_index,
    input  logic signed [CHAN_W-1:0]  i_coefficient,
    input  logic [COORD_W-1:0]        i_col,
    input  logic [COORD_W-1:0]        i_row,
    input  logic [CHAN_W-1:0]         i_red_in,
    input  logic [CHAN_W-1:0]         i_green_in,
    input  logic [CHAN_W-1:0]         i_blue_in,
    // Result channel.
    output logic                      o_valid,
    output logic [CHAN_W-1:0]         o_red_out,
    output logic [CHAN_W-1:0]         o_green_out,
    output logic [CHAN_W-1:0]         o_blue_out,
    output logic [COORD_W-1:0]        o_col_out,
    output logic [COORD_W-1:0]        o_row_out,
    // Register port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int CW  = $clog2(MAX_DIM);
    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int KCW = $clog2(MAX_KERNEL + 1);
    localparam int KD  = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW = $clog2(KD);
    // Each tap adds at most 255 * 128 in magnitude; the bias term adds at most 255 * 255.
    localparam int ACCW = $clog2(KD * 32768 + 65536) + 1;
    localparam int PW   = CHAN_W + 1 + CHAN_W;

    // Configuration registers.
    logic [6:0]        r_image_width;
    logic [6:0]        r_image_height;
    logic [3:0]        r_kernel_width;
    logic [CHAN_W-1:0] r_divisor;
    logic [CHAN_W-1:0] r_bias;
    logic [OFFS_W-1:0] r_bias_div;

    logic [CW:0]       w_eff, h_eff;
    logic [KCW-1:0]    kw_eff;
    logic [CHAN_W-1:0] div_eff;
    logic              cfg_write;

    t_state                r_state, n_state;
    logic                  accept, scan_start;
    logic [COORD_W-1:0]    r_col, r_row;
    logic                  r_rd_vld, r_rd_last, r_div_start;
    logic signed [ACCW-1:0] r_acc_r, r_acc_g, r_acc_b;

    logic                  pix_we, tap_we;
    logic [AW-1:0]         pix_raddr;
    logic [KAW-1:0]        tap_raddr;
    logic [3*CHAN_W-1:0]   pix_rdata;
    logic [CHAN_W-1:0]     tap_rdata;
    t_scan_ctl             scan_ctl;

    logic signed [PW-1:0]  prod_r, prod_g, prod_b;
    logic                  done_r, done_g, done_b, div_done;

    // Register port: writes land on the access cycle; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 7'd64;
            r_image_height <= 7'd64;
            r_kernel_width <= 4'd3;
            r_divisor      <= 8'd1;
            r_bias         <= 8'd0;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[6:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[6:0];
                REG_KERNEL_WIDTH: r_kernel_width <= pwdata[3:0];
                REG_DIVISOR:      r_divisor      <= pwdata[CHAN_W-1:0];
                REG_BIAS:         r_bias         <= pwdata[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            REG_KERNEL_WIDTH: prdata = 32'(r_kernel_width);
            REG_DIVISOR:      prdata = 32'(r_divisor);
            REG_BIAS:         prdata = 32'(r_bias);
            default:          prdata = '0;
        endcase
    end

    // Working values: zero sizes act as one, oversize values saturate.
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(r_image_width) > MAX_DIM) begin
            w_eff = (CW+1)'(MAX_DIM);
        end else begin
            w_eff = (CW+1)'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = (CW+1)'(1);
        end else if (32'(r_image_height) > MAX_DIM) begin
            h_eff = (CW+1)'(MAX_DIM);
        end else begin
            h_eff = (CW+1)'(r_image_height);
        end
        if (r_kernel_width == '0) begin
            kw_eff = KCW'(1);
        end else if (32'(r_kernel_width) > MAX_KERNEL) begin
            kw_eff = KCW'(MAX_KERNEL);
        end else begin
            kw_eff = KCW'(r_kernel_width);
        end
        div_eff = (r_divisor == '0) ? CHAN_W'(1) : r_divisor;
    end

    // The bias is applied before division as bias times divisor, kept registered. The user
    // must change the registers only while the block is idle, unchecked by the block.
    always_ff @(posedge i_clk) begin
        r_bias_div <= r_bias * div_eff;
    end

    // Sequencer.
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= scan_ctl.rd_en;
            r_rd_last   <= scan_ctl.last;
            r_div_start <= (r_state == ST_SCAN) && r_rd_vld && r_rd_last;
            o_valid     <= div_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        scan_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_FILTER)) begin
                    scan_start = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Stores. Writes are only taken while idle, so they never overlap the
    // window reads of a filter request and no forwarding is needed.
    assign pix_we = accept && (i_action == ACT_PIXEL)
                    && (32'(i_col) < MAX_DIM) && (32'(i_row) < MAX_DIM);
    assign tap_we = accept && (i_action == ACT_TAP) && (32'(i_tap_index) < KD);

    wic_ram #(
        .WIDTH (3 * CHAN_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_pixel_store (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (AW'(i_col) * AW'(MAX_DIM) + AW'(i_row)),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_re    (scan_ctl.rd_en),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    wic_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (KD)
    ) u_kernel_store (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (KAW'(i_tap_index)),
        .i_wdata (i_coefficient),
        .i_re    (scan_ctl.rd_en),
        .i_raddr (tap_raddr),
        .o_rdata (tap_rdata)
    );

    wic_scan #(
        .MAX_DIM    (MAX_DIM),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_width    (w_eff),
        .i_height   (h_eff),
        .i_kw       (kw_eff),
        .o_pix_addr (pix_raddr),
        .o_tap_addr (tap_raddr),
        .o_ctl      (scan_ctl)
    );

    // Multiply-accumulate on the read data, one window pixel per cycle.
    assign prod_r = $signed({1'b0, pix_rdata[3*CHAN_W-1:2*CHAN_W]}) * $signed(tap_rdata);
    assign prod_g = $signed({1'b0, pix_rdata[2*CHAN_W-1:CHAN_W]}) * $signed(tap_rdata);
    assign prod_b = $signed({1'b0, pix_rdata[CHAN_W-1:0]}) * $signed(tap_rdata);

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_FILTER)) begin
            r_col   <= i_col;
            r_row   <= i_row;
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else if (r_rd_vld) begin
            r_acc_r <= r_acc_r + ACCW'(prod_r);
            r_acc_g <= r_acc_g + ACCW'(prod_g);
            r_acc_b <= r_acc_b + ACCW'(prod_b);
        end
    end

    wic_div #(.W (ACCW)) u_div_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_sum     (r_acc_r),
        .i_offset  (r_bias_div),
        .i_divisor (div_eff),
        .o_done    (done_r),
        .o_quot    (o_red_out)
    );

    wic_div #(.W (ACCW)) u_div_green (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_sum     (r_acc_g),
        .i_offset  (r_bias_div),
        .i_divisor (div_eff),
        .o_done    (done_g),
        .o_quot    (o_green_out)
    );

    wic_div #(.W (ACCW)) u_div_blue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_sum     (r_acc_b),
        .i_offset  (r_bias_div),
        .i_divisor (div_eff),
        .o_done    (done_b),
        .o_quot    (o_blue_out)
    );

    assign div_done  = done_r && done_g && done_b;
    assign o_col_out = r_col;
    assign o_row_out = r_row;

    // Checks on the sequencing.
    `WIC_ASSERT_SAME(a_reads_in_scan, i_clk, i_rst_n, scan_ctl.rd_en, r_state == ST_SCAN)
    `WIC_ASSERT_NEXT(a_filter_busy, i_clk, i_rst_n, accept && (i_action == ACT_FILTER), busy)
    `WIC_ASSERT_NEXT(a_strobe_after_div, i_clk, i_rst_n, div_done, o_valid && !busy)
    `WIC_ASSERT_SAME(a_div_start_state, i_clk, i_rst_n, r_div_start, r_state == ST_DIV)

endmodule
